### hdl/conv3x3_clamp_edge_core_assert.svh
// ----------------------------------------------------------------------------
// conv3x3_clamp_edge_core assertion macros
// Shorthand for clocked implications with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_CLAMP_EDGE_CORE_ASSERT_SVH
`define CONV3X3_CLAMP_EDGE_CORE_ASSERT_SVH

// same-cycle implication
`define CCE_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CCE_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/cce_pkg.sv
// ----------------------------------------------------------------------------
// cce_pkg
// Shared constants, types and helpers of the 3x3 replicate-border convolver.
// ----------------------------------------------------------------------------
`default_nettype none

package cce_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int PIXEL_BITS = 8;
	localparam int COEF_BITS  = 8;
	localparam int TAPS       = 3;

	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_HEIGHT);
	localparam int FW_W      = 11;
	localparam int FH_W      = 13;
	localparam int KREG_W    = TAPS * COEF_BITS;
	localparam int VAL_W     = 20;
	localparam int PROD_W    = COEF_BITS + PIXEL_BITS + 1;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;

	localparam int MQ_DEPTH = 4;
	localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
	localparam int MQ_CNT_W = MQ_PTR_W + 1;
	localparam int OQ_DEPTH = 8;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = OQ_PTR_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KTOP   = 3'd0,
		REG_KMID   = 3'd1,
		REG_KBOT   = 3'd2,
		REG_WIDTH  = 3'd3,
		REG_HEIGHT = 3'd4
	} cfg_reg_t;

	typedef logic [PIXEL_BITS-1:0] pix_t;
	// [0] top, [1] middle, [2] bottom
	typedef pix_t [TAPS-1:0] col_t;
	// [0] left, [1] middle, [2] right
	typedef col_t [TAPS-1:0] nbhd_t;
	// [0] top kernel row
	typedef logic [TAPS-1:0][KREG_W-1:0] kern_t;

	// one classified pixel or drain request, up to two results
	typedef struct packed {
		nbhd_t            cols;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col_a;
		logic [COL_W-1:0] col_b;
		logic             emit_a;
		logic             emit_b;
		logic             last;
	} job_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic                    last;
	} res_t;

	function automatic logic signed [COEF_BITS-1:0] coef(input kern_t k, input int r,
		input int c);
		return k[r][c*COEF_BITS +: COEF_BITS];
	endfunction

endpackage

`default_nettype wire

### hdl/conv3x3_clamp_edge_core.sv
// ----------------------------------------------------------------------------
// conv3x3_clamp_edge_core
// 3x3 kernel over a raster pixel stream with replicated borders.
// ----------------------------------------------------------------------------
// path: a result passes stage 1, the job queue, the multiply stages and the
//   result queue; the second result of a row end follows the first
// throughput: one request per cycle while full is low; a row end yields two results and
//   the single multiply-accumulate pipe in the back delivers one result per cycle while the result queue has room
// reset: counters, queues and kernel clear, width and height read as 1;
//   line buffers are not cleared and need no clearing pass
`default_nettype none

module conv3x3_clamp_edge_core import cce_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic                 cmd,
	input  wire logic [PIXEL_BITS-1:0] pixel,
	output logic                      empty,
	input  wire logic                 pop,
	output logic signed [VAL_W-1:0]   value,
	output logic [ROW_W-1:0]          out_row,
	output logic [COL_W-1:0]          out_col,
	output logic                      last_of_frame
);

	kern_t               kern_q;
	logic [FW_W-1:0]     width_q;
	logic [FH_W-1:0]     height_q;
	logic                accept, busy, job_valid, job_pop, head_valid;
	job_t                job, head;
	logic [MQ_CNT_W-1:0] mq_cnt;
	res_t                result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_q   <= '0;
			width_q  <= FW_W'(1);
			height_q <= FH_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KTOP:   kern_q[0] <= cfg_data[KREG_W-1:0];
				REG_KMID:   kern_q[1] <= cfg_data[KREG_W-1:0];
				REG_KBOT:   kern_q[2] <= cfg_data[KREG_W-1:0];
				REG_WIDTH:  width_q   <= cfg_data[FW_W-1:0];
				REG_HEIGHT: height_q  <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// the request in stage 1 may still need a queue slot
	assign full   = (mq_cnt + MQ_CNT_W'(busy)) >= MQ_CNT_W'(MQ_DEPTH);
	assign accept = push && !full;

	cce_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cmd          (cmd),
		.pixel        (pixel),
		.frame_width  (width_q),
		.frame_height (height_q),
		.busy         (busy),
		.job_valid    (job_valid),
		.job          (job)
	);

	cce_job_q u_job_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_valid),
		.push_job   (job),
		.pop        (job_pop),
		.count      (mq_cnt),
		.head_valid (head_valid),
		.head       (head)
	);

	cce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.kernel     (kern_q),
		.pop        (pop),
		.job_pop    (job_pop),
		.empty      (empty),
		.result     (result)
	);

	assign value         = result.value;
	assign out_row       = result.row;
	assign out_col       = result.col;
	assign last_of_frame = result.last;

endmodule

`default_nettype wire

### hdl/cce_front.sv
// ----------------------------------------------------------------------------
// cce_front
// Raster counters, line buffers and window; turns each request into a job.
// ----------------------------------------------------------------------------
`default_nettype none

module cce_front import cce_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic            cmd,
	input  wire pix_t            pixel,
	input  wire logic [FW_W-1:0] frame_width,
	input  wire logic [FH_W-1:0] frame_height,
	output logic                 busy,
	output logic                 job_valid,
	output job_t                 job
);

	logic [COL_W-1:0] col_q, drain_q;
	logic [ROW_W-1:0] row_q;
	logic             draining_q;

	logic [FW_W-1:0] w_eff, wlast;
	logic [FH_W-1:0] h_eff, hlast;
	logic            is_px, is_dr, end_row, end_frame, drain_last;
	logic [FW_W-1:0] km1, k, kp1;
	logic [COL_W-1:0] raddr0, raddr1, raddr2;

	// stage 1
	logic             px_s1, dr_s1, end_row_s1, last_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	pix_t             pix_s1;

	logic [2*PIXEL_BITS-1:0] line_a_q [MAX_WIDTH];
	logic [2*PIXEL_BITS-1:0] line_b_q [MAX_WIDTH];
	logic [2*PIXEL_BITS-1:0] rd0_q, rd1_q, rd2_q, fdat_q;
	logic                    fwd0_q, fwd1_q, fwd2_q;
	logic [2*PIXEL_BITS-1:0] w0, w1, w2, wdata;
	logic                    wr_en;

	col_t win_l_q, win_m_q;
	col_t cnew;

	always_comb begin
		if (frame_width == '0) begin
			w_eff = FW_W'(1);
		end else if (frame_width > FW_W'(MAX_WIDTH)) begin
			w_eff = FW_W'(MAX_WIDTH);
		end else begin
			w_eff = frame_width;
		end
		if (frame_height == '0) begin
			h_eff = FH_W'(1);
		end else if (frame_height > FH_W'(MAX_HEIGHT)) begin
			h_eff = FH_W'(MAX_HEIGHT);
		end else begin
			h_eff = frame_height;
		end
		wlast = w_eff - FW_W'(1);
		hlast = h_eff - FH_W'(1);
	end

	assign is_px      = accept && !cmd && !draining_q;
	assign is_dr      = accept && cmd && draining_q;
	assign end_row    = {1'b0, col_q} >= wlast;
	assign end_frame  = {1'b0, row_q} >= hlast;
	assign drain_last = {1'b0, drain_q} >= wlast;

	// clamped neighbour columns for a drain request
	always_comb begin
		k   = {1'b0, drain_q};
		km1 = (drain_q == '0) ? '0 : k - FW_W'(1);
		kp1 = k + FW_W'(1);
		raddr0 = (km1 > wlast) ? wlast[COL_W-1:0] : km1[COL_W-1:0];
		raddr1 = (k > wlast) ? wlast[COL_W-1:0] : k[COL_W-1:0];
		raddr2 = (kp1 > wlast) ? wlast[COL_W-1:0] : kp1[COL_W-1:0];
		if (!draining_q) begin
			raddr0 = col_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			drain_q    <= '0;
			draining_q <= 1'b0;
		end else if (is_px) begin
			if (end_row) begin
				col_q <= '0;
				if (end_frame) begin
					draining_q <= 1'b1;
					drain_q    <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end else if (is_dr) begin
			if (drain_last) begin
				draining_q <= 1'b0;
				drain_q    <= '0;
				row_q      <= '0;
				col_q      <= '0;
			end else begin
				drain_q <= drain_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_s1  <= 1'b0;
			dr_s1  <= 1'b0;
			fwd0_q <= 1'b0;
			fwd1_q <= 1'b0;
			fwd2_q <= 1'b0;
		end else begin
			px_s1  <= is_px;
			dr_s1  <= is_dr;
			// read of the entry being written this cycle takes the new word
			fwd0_q <= wr_en && (col_s1 == raddr0);
			fwd1_q <= wr_en && (col_s1 == raddr1);
			fwd2_q <= wr_en && (col_s1 == raddr2);
		end
	end

	always_ff @(posedge clk) begin
		col_s1     <= is_dr ? drain_q : col_q;
		row_s1     <= row_q;
		pix_s1     <= pixel;
		end_row_s1 <= end_row;
		last_s1    <= drain_last;
		fdat_q     <= wdata;
	end

	// word: above line in the high byte, current line in the low byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_a_q[col_s1] <= wdata;
			line_b_q[col_s1] <= wdata;
		end
		rd0_q <= line_a_q[raddr0];
		rd1_q <= line_a_q[raddr1];
		rd2_q <= line_b_q[raddr2];
	end

	assign w0    = fwd0_q ? fdat_q : rd0_q;
	assign w1    = fwd1_q ? fdat_q : rd1_q;
	assign w2    = fwd2_q ? fdat_q : rd2_q;
	assign wr_en = px_s1;
	assign wdata = {w0[PIXEL_BITS-1:0], pix_s1};
	assign busy  = px_s1 || dr_s1;

	always_comb begin
		cnew[0] = (row_s1 >= ROW_W'(2)) ? w0[2*PIXEL_BITS-1:PIXEL_BITS] : w0[PIXEL_BITS-1:0];
		cnew[1] = w0[PIXEL_BITS-1:0];
		cnew[2] = pix_s1;
	end

	always_ff @(posedge clk) begin
		if (px_s1 && row_s1 != '0) begin
			if (col_s1 == '0) begin
				win_l_q <= cnew;
			end else begin
				win_l_q <= win_m_q;
			end
			win_m_q <= cnew;
		end
	end

	always_comb begin
		job       = '0;
		job_valid = 1'b0;
		if (px_s1) begin
			job.row    = row_s1 - ROW_W'(1);
			job.col_a  = col_s1 - COL_W'(1);
			job.col_b  = col_s1;
			job.emit_a = col_s1 != '0;
			job.emit_b = end_row_s1;
			job.last   = 1'b0;
			if (col_s1 == '0) begin
				job.cols = {cnew, cnew, cnew};
			end else begin
				job.cols = {cnew, win_m_q, win_l_q};
			end
			job_valid = (row_s1 != '0) && (job.emit_a || job.emit_b);
		end else if (dr_s1) begin
			job.cols[0][0] = (row_s1 != '0) ? w0[2*PIXEL_BITS-1:PIXEL_BITS] : w0[PIXEL_BITS-1:0];
			job.cols[0][1] = w0[PIXEL_BITS-1:0];
			job.cols[0][2] = w0[PIXEL_BITS-1:0];
			job.cols[1][0] = (row_s1 != '0) ? w1[2*PIXEL_BITS-1:PIXEL_BITS] : w1[PIXEL_BITS-1:0];
			job.cols[1][1] = w1[PIXEL_BITS-1:0];
			job.cols[1][2] = w1[PIXEL_BITS-1:0];
			job.cols[2][0] = (row_s1 != '0) ? w2[2*PIXEL_BITS-1:PIXEL_BITS] : w2[PIXEL_BITS-1:0];
			job.cols[2][1] = w2[PIXEL_BITS-1:0];
			job.cols[2][2] = w2[PIXEL_BITS-1:0];
			job.row    = row_s1;
			job.col_a  = col_s1;
			job.col_b  = col_s1;
			job.emit_a = 1'b1;
			job.emit_b = 1'b0;
			job.last   = last_s1;
			job_valid  = 1'b1;
		end
	end

endmodule

`default_nettype wire

### hdl/cce_job_q.sv
// ----------------------------------------------------------------------------
// cce_job_q
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cce_job_q import cce_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire job_t          push_job,
	input  wire logic          pop,
	output logic [MQ_CNT_W-1:0] count,
	output logic               head_valid,
	output job_t               head
);

	job_t                slot_q [MQ_DEPTH];
	logic [MQ_PTR_W-1:0] wr_q, rd_q;
	logic [MQ_CNT_W-1:0] cnt_q;
	logic                do_pop;

	assign do_pop     = pop && (cnt_q != '0);
	assign count      = cnt_q;
	assign head_valid = cnt_q != '0;
	assign head       = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + MQ_PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + MQ_PTR_W'(1);
			end
			cnt_q <= cnt_q + MQ_CNT_W'(push) - MQ_CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

### hdl/cce_back.sv
// ----------------------------------------------------------------------------
// cce_back
// Expands jobs into results, multiplies and sums, queues results.
// ----------------------------------------------------------------------------
`default_nettype none

module cce_back import cce_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  head_valid,
	input  wire job_t  head,
	input  wire kern_t kernel,
	input  wire logic  pop,
	output logic       job_pop,
	output logic       empty,
	output res_t       result
);

	logic                phase_q;
	logic                issue, second, credit;
	logic [OQ_CNT_W:0]   pending;

	logic                v_s1, v_s2;
	nbhd_t               cols_s1;
	logic [ROW_W-1:0]    row_s1, row_s2;
	logic [COL_W-1:0]    col_s1, col_s2;
	logic                last_s1, last_s2;
	logic signed [PROD_W-1:0] prod [TAPS][TAPS];
	logic signed [PROD_W-1:0] prod_s2 [TAPS][TAPS];
	logic signed [VAL_W-1:0]  sum;

	res_t                oq_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] owr_q, ord_q;
	logic [OQ_CNT_W-1:0] ocnt_q;
	logic                do_pop;

	// room counts results still in the multiply stages
	assign pending = (OQ_CNT_W+1)'(ocnt_q) + (OQ_CNT_W+1)'(v_s1) + (OQ_CNT_W+1)'(v_s2);
	assign credit  = pending < (OQ_CNT_W+1)'(OQ_DEPTH);
	assign issue   = head_valid && credit;
	assign second  = phase_q || !head.emit_a;
	assign job_pop = issue && (second || !head.emit_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (issue) begin
				phase_q <= !second && head.emit_b;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (second) begin
			cols_s1 <= {head.cols[2], head.cols[2], head.cols[1]};
			col_s1  <= head.col_b;
		end else begin
			cols_s1 <= head.cols;
			col_s1  <= head.col_a;
		end
		row_s1  <= head.row;
		last_s1 <= head.last && !second;
		row_s2  <= row_s1;
		col_s2  <= col_s1;
		last_s2 <= last_s1;
		prod_s2 <= prod;
	end

	always_comb begin
		for (int r = 0; r < TAPS; r++) begin
			for (int c = 0; c < TAPS; c++) begin
				prod[r][c] = coef(kernel, r, c) * $signed({1'b0, cols_s1[c][r]});
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int r = 0; r < TAPS; r++) begin
			for (int c = 0; c < TAPS; c++) begin
				sum = sum + VAL_W'(prod_s2[r][c]);
			end
		end
	end

	assign do_pop = pop && (ocnt_q != '0);
	assign empty  = ocnt_q == '0;
	assign result = oq_q[ord_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (v_s2) begin
				owr_q <= owr_q + OQ_PTR_W'(1);
			end
			if (do_pop) begin
				ord_q <= ord_q + OQ_PTR_W'(1);
			end
			ocnt_q <= ocnt_q + OQ_CNT_W'(v_s2) - OQ_CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			oq_q[owr_q] <= '{value: sum, row: row_s2, col: col_s2, last: last_s2};
		end
	end

endmodule

`default_nettype wire

### hdl/cce_checker.sv
// ----------------------------------------------------------------------------
// cce_checker
// Port-level checks of the convolver's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "conv3x3_clamp_edge_core_assert.svh"

module cce_checker import cce_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 empty,
	input wire logic                 pop,
	input wire logic signed [VAL_W-1:0] value,
	input wire logic [ROW_W-1:0]     out_row,
	input wire logic [COL_W-1:0]     out_col,
	input wire logic                 last_of_frame
);

	// a waiting result holds until taken
	`CCE_ASSERT_NXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(value) && $stable(out_row) && $stable(out_col), "result changed while waiting")

	// out of reset nothing is waiting
	`CCE_ASSERT_IMP(a_rst_empty, clk, arst_n, $rose(arst_n), empty, "result present after reset")

	// a frame ends and the next one starts at the top left
	`CCE_ASSERT_NXT(a_new_frame, clk, arst_n, !empty && pop && last_of_frame, empty || (out_row == '0 && out_col == '0), "new frame does not start at origin")

	// the origin only follows the end of a frame
	`CCE_ASSERT_NXT(a_origin, clk, arst_n, !empty && pop && !last_of_frame, empty || out_row != '0 || out_col != '0, "origin result inside a frame")

endmodule

bind conv3x3_clamp_edge_core cce_checker u_cce_checker (.*);

`default_nettype wire
